### rtl/tsf_pkg.sv
package tsf_pkg;

	// Blink divider reload and saturation value of the period counter.
	localparam logic [7:0] BLINK_TICKS = 8'd61;
	localparam logic [7:0] PERIOD_CAP  = 8'd200;

	// Limits of the lamp pattern shown while a lamp fault is latched.
	localparam logic [7:0] MALF_FIRST_END  = 8'd19;
	localparam logic [7:0] MALF_DARK_END   = 8'd40;
	localparam logic [7:0] MALF_SECOND_END = 8'd61;

	// Configuration register indexes.
	localparam logic [1:0] REG_DEBOUNCE_TARGET = 2'd0;
	localparam logic [1:0] REG_RELEASE_PERIODS = 2'd1;
	localparam logic [1:0] REG_WARN_PERIODS    = 2'd2;

	localparam logic [7:0] DEBOUNCE_TARGET_RST = 8'd5;
	localparam logic [7:0] RELEASE_PERIODS_RST = 8'd3;
	localparam logic [7:0] WARN_PERIODS_RST    = 8'd9;

	typedef struct packed {
		logic [7:0] debounce_target;
		logic [7:0] release_periods;
		logic [7:0] warn_periods;
	} cfg_t;

	typedef struct packed {
		logic left;
		logic right;
		logic thanks;
		logic malfunction;
	} mode_t;

	typedef struct packed {
		logic button_n;
		logic right_sense;
		logic left_sense;
		logic comparator_trip;
	} tick_t;

	typedef struct packed {
		logic relay_left;
		logic relay_right;
		logic blink_clock;
		logic lamp_a;
		logic lamp_b;
	} result_t;

endpackage

### rtl/tsf_tick_if.sv
interface tsf_tick_if;
	logic valid;
	logic ready;
	logic button_n;
	logic right_sense;
	logic left_sense;
	logic comparator_trip;

	modport source (output valid, output button_n, output right_sense, output left_sense,
		output comparator_trip, input ready);
	modport sink (input valid, input button_n, input right_sense, input left_sense,
		input comparator_trip, output ready);
endinterface

### rtl/tsf_result_if.sv
interface tsf_result_if;
	logic valid;
	logic ready;
	logic relay_left;
	logic relay_right;
	logic blink_clock;
	logic lamp_a;
	logic lamp_b;

	modport source (output valid, output relay_left, output relay_right, output blink_clock,
		output lamp_a, output lamp_b, input ready);
	modport sink (input valid, input relay_left, input relay_right, input blink_clock,
		input lamp_a, input lamp_b, output ready);
endinterface

### rtl/tsf_cfg.sv
module tsf_cfg
	import tsf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       we,
	input  logic [1:0] index,
	input  logic [7:0] data,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_target <= DEBOUNCE_TARGET_RST;
			cfg_q.release_periods <= RELEASE_PERIODS_RST;
			cfg_q.warn_periods    <= WARN_PERIODS_RST;
		end else if (we) begin
			case (index)
				REG_DEBOUNCE_TARGET: cfg_q.debounce_target <= data;
				REG_RELEASE_PERIODS: cfg_q.release_periods <= data;
				REG_WARN_PERIODS:    cfg_q.warn_periods <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/tsf_core.sv
module tsf_core
	import tsf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  tick_t   item,
	input  cfg_t    cfg,
	output result_t res_next
);

	logic [7:0] debounce_q, debounce_d;
	logic [7:0] divider_q, divider_d;
	logic [7:0] period_q, period_d;
	logic       phase_q, phase_d;
	mode_t      mode_q, mode_d;
	result_t    latch_q, latch_d;
	logic       pressed;
	logic       one_side;

	always_comb begin
		debounce_d = debounce_q;
		divider_d  = divider_q;
		period_d   = period_q;
		phase_d    = phase_q;
		mode_d     = mode_q;
		latch_d    = latch_q;
		pressed    = !item.button_n;
		one_side   = item.right_sense ^ item.left_sense;

		// Thanks flash debounce; the count stops one past the target.
		if (!mode_d.thanks) begin
			if (pressed) begin
				if ({1'b0, debounce_d} < ({1'b0, cfg.debounce_target} + 9'd1))
					debounce_d = debounce_d + 8'd1;
				if (debounce_d == cfg.debounce_target) begin
					latch_d.relay_left  = 1'b1;
					latch_d.relay_right = 1'b1;
					period_d            = '0;
					mode_d.thanks       = 1'b1;
				end
			end else begin
				debounce_d = '0;
			end
		end

		divider_d = divider_d - 8'd1;
		if (divider_d == 8'd0) begin
			divider_d           = BLINK_TICKS;
			latch_d.blink_clock = !latch_d.blink_clock;
			phase_d             = !phase_d;
			if (phase_d && (mode_d.left || mode_d.right || mode_d.thanks) &&
			    (period_d < PERIOD_CAP))
				period_d = period_d + 8'd1;
		end

		if (phase_d) begin
			if (!item.right_sense && !item.left_sense) begin
				mode_d.malfunction = 1'b0;
				mode_d.left        = 1'b0;
				mode_d.right       = 1'b0;
			end else if (item.right_sense && !item.left_sense) begin
				if (!mode_d.right) begin
					mode_d.right        = 1'b1;
					period_d            = '0;
					latch_d.relay_right = 1'b1;
				end
			end else if (item.left_sense && !item.right_sense) begin
				if (!mode_d.left) begin
					mode_d.left        = 1'b1;
					period_d           = '0;
					latch_d.relay_left = 1'b1;
				end
			end else begin
				latch_d.lamp_a = 1'b1;
				if (!mode_d.thanks) begin
					latch_d.relay_left  = 1'b0;
					latch_d.relay_right = 1'b0;
				end
				mode_d.left  = 1'b0;
				mode_d.right = 1'b0;
			end
			if (one_side) begin
				if (mode_d.malfunction) begin
					// Fault pattern: lit, dark, lit across the on phase of one blink period.
					if (divider_d <= MALF_FIRST_END) begin
						latch_d.lamp_a = 1'b1;
						latch_d.lamp_b = 1'b1;
					end else if (divider_d <= MALF_DARK_END) begin
						latch_d.lamp_a = 1'b0;
						latch_d.lamp_b = 1'b0;
					end else if (divider_d <= MALF_SECOND_END) begin
						latch_d.lamp_a = 1'b1;
						latch_d.lamp_b = 1'b1;
					end
				end else begin
					latch_d.lamp_a = 1'b1;
					if (period_d > cfg.warn_periods)
						latch_d.lamp_b = 1'b1;
				end
				if (item.comparator_trip)
					mode_d.malfunction = 1'b1;
			end
		end else begin
			latch_d.lamp_a = 1'b0;
			latch_d.lamp_b = 1'b0;
			if (period_d >= cfg.release_periods) begin
				latch_d.relay_left  = 1'b0;
				latch_d.relay_right = 1'b0;
				mode_d.thanks       = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= '0;
			divider_q  <= BLINK_TICKS;
			period_q   <= '0;
			phase_q    <= 1'b0;
			mode_q     <= '0;
			latch_q    <= '0;
		end else if (en) begin
			debounce_q <= debounce_d;
			divider_q  <= divider_d;
			period_q   <= period_d;
			phase_q    <= phase_d;
			mode_q     <= mode_d;
			latch_q    <= latch_d;
		end
	end

	assign res_next = latch_d;

`ifndef SYNTHESIS
	a_period_capped: assert property (@(posedge clk) disable iff (!arst_n)
		period_q <= PERIOD_CAP)
		else $error("period counter above its cap");

	a_divider_range: assert property (@(posedge clk) disable iff (!arst_n)
		(divider_q != 8'd0) && (divider_q <= BLINK_TICKS))
		else $error("blink divider out of range");

	a_lamps_dark_off_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!phase_q |-> (!latch_q.lamp_a && !latch_q.lamp_b))
		else $error("indicator lamp lit during off phase");

	a_idle_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(divider_q) && $stable(mode_q) && $stable(latch_q)))
		else $error("state changed without an item");
`endif

endmodule

### rtl/turn_signal_flasher_controller_unit.sv
// Turn-signal flasher controller. Each item on tick is one timer tick carrying the
// button level, the lamp feedback and the fault comparator; each item on result carries
// the relay, blink clock and indicator lamp levels after that tick. One item is taken per
// clock cycle when result is not stalled; an accepted item passes an input register, then
// the state update and the result register. Config registers (debounce target, release
// periods, warn periods) are written through cfg_we, cfg_index and cfg_data and should
// only change while no item is in flight.
module turn_signal_flasher_controller_unit
	import tsf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	tsf_tick_if.sink   tick,
	tsf_result_if.source result,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	cfg_t    cfg;
	tick_t   item_s1;
	logic    valid_s1;
	result_t res_next;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;

	tsf_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// The buffered item moves on whenever the result register is free or being emptied.
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign tick.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			item_s1.button_n        <= tick.button_n;
			item_s1.right_sense     <= tick.right_sense;
			item_s1.left_sense      <= tick.left_sense;
			item_s1.comparator_trip <= tick.comparator_trip;
		end
	end

	tsf_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.item     (item_s1),
		.cfg      (cfg),
		.res_next (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res_next;
	end

	assign result.valid       = valid_s2;
	assign result.relay_left  = res_s2.relay_left;
	assign result.relay_right = res_s2.relay_right;
	assign result.blink_clock = res_s2.blink_clock;
	assign result.lamp_a      = res_s2.lamp_a;
	assign result.lamp_b      = res_s2.lamp_b;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !result.ready) |-> !advance)
		else $error("result register overwritten while stalled");

	a_stall_backs_up: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !result.ready) |-> !tick.ready)
		else $error("item taken while both stages are full");

	a_buffer_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !valid_s2) |=> valid_s2)
		else $error("buffered item did not reach the result register");
`endif

endmodule
